// ===== hw/rtl/ocp_pkg.sv =====
// Package for the orbit camera position core: payload structs, event codes,
// fixed-point constants and the CORDIC arctangent table. No dependencies.
`default_nettype none

package ocp_pkg;

    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int ATAN_DEPTH          = 24;
    localparam int ATAN_IDX_W          = $clog2(ATAN_DEPTH);

    localparam logic [1:0] MODE_WHEEL = 2'd0;
    localparam logic [1:0] MODE_MOVE  = 2'd1;
    localparam logic [1:0] MODE_FRAME = 2'd2;

    localparam logic [14:0] FULL_TURN          = 15'd23040;
    localparam logic [14:0] HALF_TURN          = 15'd11520;
    localparam logic [14:0] QUARTER_TURN       = 15'd5760;
    localparam logic [14:0] THREE_QUARTER_TURN = 15'd17280;

    localparam logic [23:0] DIST_RESET  = 24'd12800;
    localparam logic [23:0] DIST_MAX    = 24'hFFFFFF;
    localparam logic [14:0] TILT_RESET  = 15'd1280;

    localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sd652032874;
    localparam logic [23:0] DIV5_RECIP  = 24'd13421773;
    localparam logic [10:0] DIV45_RECIP = 11'd1457;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [7:0]  wheel_delta;
        logic signed [15:0] mouse_dx;
        logic signed [15:0] mouse_dy;
        logic               left_button;
        logic               right_button;
        logic signed [23:0] player_x;
        logic signed [23:0] player_y;
        logic signed [23:0] player_z;
        logic [14:0]        player_heading;
    } ocp_in_t;

    typedef struct packed {
        logic signed [23:0] camera_x;
        logic signed [23:0] camera_y;
        logic signed [23:0] camera_z;
        logic [14:0]        camera_pitch;
        logic [14:0]        camera_yaw;
    } ocp_out_t;

    // Arctangent of 2^-i in units of 2^-22 degree.
    function automatic logic [27:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [27:0] v;
        case (idx)
            5'd0:    v = 28'd188743680;
            5'd1:    v = 28'd111421900;
            5'd2:    v = 28'd58872272;
            5'd3:    v = 28'd29884485;
            5'd4:    v = 28'd15000234;
            5'd5:    v = 28'd7507429;
            5'd6:    v = 28'd3754631;
            5'd7:    v = 28'd1877430;
            5'd8:    v = 28'd938729;
            5'd9:    v = 28'd469366;
            5'd10:   v = 28'd234683;
            5'd11:   v = 28'd117342;
            5'd12:   v = 28'd58671;
            5'd13:   v = 28'd29335;
            5'd14:   v = 28'd14668;
            5'd15:   v = 28'd7334;
            5'd16:   v = 28'd3667;
            5'd17:   v = 28'd1833;
            5'd18:   v = 28'd917;
            5'd19:   v = 28'd458;
            5'd20:   v = 28'd229;
            5'd21:   v = 28'd115;
            5'd22:   v = 28'd57;
            5'd23:   v = 28'd29;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/orbit_camera_position_core.sv =====
// A wheel transfer only stores the zoom step and a move transfer only stores the turn
// and tilt steps; neither produces a result. A frame transfer produces one camera pose.
// One shared CORDIC stage runs twice per frame and one shared 26x32 multiplier
// serves the divide-by-5 reciprocal products and the four position products.
// New transfers are taken only in idle; a finished frame waits while a result is held.
// Reset (aresetn low, synchronous) restores distance 50.0, pitch 20 degrees.
`default_nettype none

module orbit_camera_position_core #(
    parameter int TRIG_ITERATIONS = ocp_pkg::TRIG_ITERATIONS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ocp_pkg::ocp_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ocp_pkg::ocp_out_t     m_data
);
    import ocp_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_TURN_MUL = 4'd1;
    localparam logic [3:0] S_TURN_RED = 4'd2;
    localparam logic [3:0] S_TURN_WR  = 4'd3;
    localparam logic [3:0] S_TILT_WR  = 4'd4;
    localparam logic [3:0] S_APPLY    = 4'd5;
    localparam logic [3:0] S_THETA    = 4'd6;
    localparam logic [3:0] S_CORD1    = 4'd7;
    localparam logic [3:0] S_MUL_H    = 4'd8;
    localparam logic [3:0] S_MUL_V    = 4'd9;
    localparam logic [3:0] S_CORD2    = 4'd10;
    localparam logic [3:0] S_MUL_X    = 4'd11;
    localparam logic [3:0] S_MUL_Z    = 4'd12;
    localparam logic [3:0] S_FINISH   = 4'd13;

    localparam logic [ATAN_IDX_W-1:0] ITER_LAST = ATAN_IDX_W'(TRIG_ITERATIONS - 1);

    logic [3:0]               state_reg;
    ocp_in_t                  in_reg;
    logic [23:0]              dist_reg;
    logic [14:0]              tilt_reg;
    logic [14:0]              orbit_reg;
    logic signed [7:0]        zoom_reg;
    logic [14:0]              pturn_reg;
    logic [14:0]              ptilt_reg;
    logic [19:0]              mag_reg;
    logic [4:0]               qq_reg;
    logic [14:0]              theta_reg;
    logic signed [31:0]       cx_reg;
    logic signed [31:0]       cy_reg;
    logic signed [31:0]       cz_reg;
    logic                     flip_reg;
    logic [ATAN_IDX_W-1:0]    iter_reg;
    logic signed [57:0]       p_reg;
    logic signed [25:0]       horiz_reg;
    logic signed [23:0]       cam_x_reg;
    logic signed [23:0]       cam_y_reg;
    logic                     m_valid_reg;
    ocp_out_t                 m_data_reg;

    logic                     mul_en;
    logic signed [25:0]       mul_a;
    logic signed [31:0]       mul_b;
    logic signed [57:0]       mul_p;
    logic signed [57:0]       p_rnd;
    logic signed [27:0]       prod_q8;
    logic [19:0]              div_q;
    logic [20:0]              div45_prod;
    logic [4:0]               div45_q;
    logic [16:0]              abs_dx;
    logic [16:0]              abs_dy;
    logic [21:0]              v_turn;
    logic [21:0]              v_tilt;
    logic signed [31:0]       xs;
    logic signed [31:0]       ys;
    logic signed [31:0]       at;
    logic signed [31:0]       cos_val;
    logic signed [31:0]       sin_val;
    logic                     out_free;

    function automatic logic [14:0] wrap_mag(input logic [19:0] mag, input logic [4:0] qq,
                                             input logic neg);
        logic [19:0] r20;
        logic [14:0] r;
        r20 = mag - 20'(qq) * 20'(FULL_TURN);
        r = r20[14:0];
        if (neg && (r != 15'd0)) begin
            r = FULL_TURN - r;
        end
        return r;
    endfunction

    function automatic logic [32:0] cordic_fold(input logic [14:0] a);
        logic signed [15:0] ang;
        logic               flip;
        flip = 1'b0;
        ang = signed'({1'b0, a});
        if (a >= THREE_QUARTER_TURN) begin
            ang = signed'({1'b0, a}) - signed'({1'b0, FULL_TURN});
        end else if (a > QUARTER_TURN) begin
            ang = signed'({1'b0, a}) - signed'({1'b0, HALF_TURN});
            flip = 1'b1;
        end
        return {flip, 32'(ang) <<< 16};
    endfunction

    function automatic logic signed [23:0] sat_coord(input logic signed [28:0] v);
        logic signed [23:0] r;
        if (v > 29'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -29'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign abs_dx = in_reg.mouse_dx[15] ? (17'd0 - 17'(in_reg.mouse_dx)) : 17'(in_reg.mouse_dx);
    assign abs_dy = in_reg.mouse_dy[15] ? (17'd0 - 17'(in_reg.mouse_dy)) : 17'(in_reg.mouse_dy);
    assign v_turn = 22'(abs_dx) * 22'd96 + 22'd2;
    assign v_tilt = 22'(abs_dy) * 22'd32 + 22'd2;

    assign div_q      = p_reg[45:26];
    assign div45_prod = 21'(div_q[19:9]) * 21'(DIV45_RECIP);
    assign div45_q    = div45_prod[20:16];

    assign p_rnd   = p_reg + (58'sd1 <<< 29);
    assign prod_q8 = p_rnd[57:30];

    assign xs      = cx_reg >>> iter_reg;
    assign ys      = cy_reg >>> iter_reg;
    assign at      = signed'(32'(atan_entry(iter_reg)));
    assign cos_val = flip_reg ? -cx_reg : cx_reg;
    assign sin_val = flip_reg ? -cy_reg : cy_reg;

    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            S_TURN_MUL: begin
                mul_en = 1'b1;
                mul_a  = signed'(26'(v_turn));
                mul_b  = signed'(32'(DIV5_RECIP));
            end
            S_TURN_RED: begin
                mul_en = 1'b1;
                mul_a  = signed'(26'(v_tilt));
                mul_b  = signed'(32'(DIV5_RECIP));
            end
            S_MUL_H: begin
                mul_en = 1'b1;
                mul_a  = signed'(26'(dist_reg));
                mul_b  = cos_val;
            end
            S_MUL_V: begin
                mul_en = 1'b1;
                mul_a  = signed'(26'(dist_reg));
                mul_b  = sin_val;
            end
            S_MUL_X: begin
                mul_en = 1'b1;
                mul_a  = horiz_reg;
                mul_b  = sin_val;
            end
            S_MUL_Z: begin
                mul_en = 1'b1;
                mul_a  = horiz_reg;
                mul_b  = cos_val;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        logic signed [25:0] d;
        logic [15:0]        tsum;
        logic signed [15:0] odiff;
        logic [14:0]        head;
        logic [15:0]        hsum;
        logic signed [16:0] yaw;
        logic [32:0]        fold;
        if (mul_en) begin
            p_reg <= mul_p;
        end
        if (state_reg == S_IDLE && s_valid) begin
            in_reg <= s_data;
        end
        case (state_reg)
            S_TURN_RED: begin
                mag_reg <= div_q;
                qq_reg  <= div45_q;
            end
            S_TURN_WR: begin
                mag_reg <= div_q;
                qq_reg  <= div45_q;
            end
            S_THETA: begin
                head = (in_reg.player_heading >= FULL_TURN) ?
                       (in_reg.player_heading - FULL_TURN) : in_reg.player_heading;
                hsum = 16'(head) + 16'(orbit_reg);
                theta_reg <= (hsum >= 16'(FULL_TURN)) ? 15'(hsum - 16'(FULL_TURN)) : hsum[14:0];
                fold = cordic_fold(tilt_reg);
                flip_reg <= fold[32];
                cz_reg   <= fold[31:0];
                cx_reg   <= CORDIC_GAIN_INV;
                cy_reg   <= '0;
                iter_reg <= '0;
            end
            S_MUL_V: begin
                horiz_reg <= prod_q8[25:0];
                fold = cordic_fold(theta_reg);
                flip_reg <= fold[32];
                cz_reg   <= fold[31:0];
                cx_reg   <= CORDIC_GAIN_INV;
                cy_reg   <= '0;
                iter_reg <= '0;
            end
            S_CORD1, S_CORD2: begin
                if (!cz_reg[31]) begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - at;
                end else begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + at;
                end
                iter_reg <= iter_reg + 1'b1;
                if (state_reg == S_CORD2) begin
                    cam_y_reg <= sat_coord(29'(in_reg.player_y) + 29'(prod_q8));
                end
            end
            S_MUL_Z: begin
                cam_x_reg <= sat_coord(29'(in_reg.player_x) - 29'(prod_q8));
            end
            S_FINISH: begin
                if (out_free) begin
                    yaw = 17'(HALF_TURN) - 17'(theta_reg);
                    if (yaw < 0) begin
                        yaw = yaw + 17'(FULL_TURN);
                    end
                    m_data_reg.camera_x     <= cam_x_reg;
                    m_data_reg.camera_y     <= cam_y_reg;
                    m_data_reg.camera_z     <= sat_coord(29'(in_reg.player_z) - 29'(prod_q8));
                    m_data_reg.camera_pitch <= tilt_reg;
                    m_data_reg.camera_yaw   <= yaw[14:0];
                end
            end
            default: begin
            end
        endcase

        if (!aresetn) begin
            state_reg   <= S_IDLE;
            dist_reg    <= DIST_RESET;
            tilt_reg    <= TILT_RESET;
            orbit_reg   <= '0;
            zoom_reg    <= '0;
            pturn_reg   <= '0;
            ptilt_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        case (s_data.mode)
                            MODE_WHEEL: zoom_reg <= s_data.wheel_delta;
                            MODE_MOVE:  state_reg <= S_TURN_MUL;
                            MODE_FRAME: state_reg <= S_APPLY;
                            default:    state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_TURN_MUL: state_reg <= S_TURN_RED;
                S_TURN_RED: state_reg <= S_TURN_WR;
                S_TURN_WR: begin
                    pturn_reg <= wrap_mag(mag_reg, qq_reg, in_reg.mouse_dx[15]);
                    state_reg <= S_TILT_WR;
                end
                S_TILT_WR: begin
                    ptilt_reg <= wrap_mag(mag_reg, qq_reg, in_reg.mouse_dy[15]);
                    state_reg <= S_IDLE;
                end
                S_APPLY: begin
                    d = signed'(26'(dist_reg)) - (26'(zoom_reg) <<< 8);
                    if (d < 0) begin
                        dist_reg <= '0;
                    end else if (d > signed'(26'(DIST_MAX))) begin
                        dist_reg <= DIST_MAX;
                    end else begin
                        dist_reg <= d[23:0];
                    end
                    zoom_reg <= '0;
                    if (in_reg.right_button) begin
                        tsum = 16'(tilt_reg) + 16'(ptilt_reg);
                        tilt_reg  <= (tsum >= 16'(FULL_TURN)) ?
                                     15'(tsum - 16'(FULL_TURN)) : tsum[14:0];
                        ptilt_reg <= '0;
                    end
                    if (in_reg.left_button) begin
                        odiff = signed'(16'(orbit_reg)) - signed'(16'(pturn_reg));
                        orbit_reg <= (odiff < 0) ? 15'(odiff + signed'(16'(FULL_TURN))) :
                                     odiff[14:0];
                        pturn_reg <= '0;
                    end
                    state_reg <= S_THETA;
                end
                S_THETA: state_reg <= S_CORD1;
                S_CORD1: begin
                    if (iter_reg == ITER_LAST) begin
                        state_reg <= S_MUL_H;
                    end
                end
                S_MUL_H: state_reg <= S_MUL_V;
                S_MUL_V: state_reg <= S_CORD2;
                S_CORD2: begin
                    if (iter_reg == ITER_LAST) begin
                        state_reg <= S_MUL_X;
                    end
                end
                S_MUL_X: state_reg <= S_MUL_Z;
                S_MUL_Z: state_reg <= S_FINISH;
                S_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for orbit_camera_position_core: drives wheel, move and frame
// transfers with random gaps, predicts each camera pose and compares it field by field.
// Depends on ocp_pkg for the payload structs and event codes.
`default_nettype none

class camera_scoreboard;
    localparam longint TURN = 23040;
    localparam longint HALF = 11520;
    localparam longint QUARTER = 5760;
    localparam longint COORD_HI = 8388607;
    localparam longint COORD_LO = -8388608;
    localparam longint DIST_TOP = 16777215;
    localparam longint GAIN = 652032874;
    localparam int ROTATIONS = ocp_pkg::TRIG_ITERATIONS_DEF;

    logic [23:0]        distance;
    logic [14:0]        pitch;
    logic [14:0]        orbit;
    logic signed [7:0]  zoom_step;
    logic signed [20:0] turn_step;
    logic signed [18:0] tilt_step;
    longint             arctan[24];
    ocp_pkg::ocp_out_t  pose_q[$];
    int                 errors;

    function new();
        arctan = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
                   3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
        distance = 24'd12800;
        pitch = 15'd1280;
        orbit = 15'd0;
        zoom_step = 8'sd0;
        turn_step = 21'sd0;
        tilt_step = 19'sd0;
        errors = 0;
    endfunction

    function int backlog();
        return pose_q.size();
    endfunction

    function logic [14:0] wrap_turn(longint v);
        longint r;
        r = v % TURN;
        if (r < 0) begin
            r += TURN;
        end
        return r[14:0];
    endfunction

    function longint round_fifth(longint num);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag * 2 + 5) / 10;
        return (num < 0) ? -q : q;
    endfunction

    function longint scale_q30(longint a, longint t);
        return (a * t + 64'sd536870912) >>> 30;
    endfunction

    function logic signed [23:0] clamp_coord(longint v);
        if (v > COORD_HI) begin
            v = COORD_HI;
        end
        if (v < COORD_LO) begin
            v = COORD_LO;
        end
        return v[23:0];
    endfunction

    function void sin_cos(input logic [14:0] a, output longint s, output longint c);
        longint ang, x, y, z, xs, ys;
        bit     flip;
        ang = longint'(a) % TURN;
        flip = 1'b0;
        x = GAIN;
        y = 0;
        if (ang >= 3 * QUARTER) begin
            ang -= TURN;
        end else if (ang > QUARTER) begin
            ang -= HALF;
            flip = 1'b1;
        end
        z = ang * 65536;
        for (int i = 0; i < ROTATIONS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= arctan[i];
            end else begin
                x += ys;
                y -= xs;
                z += arctan[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function ocp_pkg::ocp_out_t frame_pose(ocp_pkg::ocp_in_t it);
        ocp_pkg::ocp_out_t p;
        longint            d, sp, cp, st, ct, horiz, vert;
        logic [14:0]       theta;
        d = longint'(distance) - longint'(zoom_step) * 256;
        if (d < 0) begin
            d = 0;
        end
        if (d > DIST_TOP) begin
            d = DIST_TOP;
        end
        distance = d[23:0];
        zoom_step = 8'sd0;
        if (it.right_button) begin
            pitch = wrap_turn(longint'(pitch) + longint'(tilt_step));
            tilt_step = 19'sd0;
        end
        if (it.left_button) begin
            orbit = wrap_turn(longint'(orbit) - longint'(turn_step));
            turn_step = 21'sd0;
        end
        theta = wrap_turn(longint'(it.player_heading) % TURN + longint'(orbit));
        sin_cos(pitch, sp, cp);
        horiz = scale_q30(longint'(distance), cp);
        vert = scale_q30(longint'(distance), sp);
        sin_cos(theta, st, ct);
        p.camera_x = clamp_coord(longint'(it.player_x) - scale_q30(horiz, st));
        p.camera_y = clamp_coord(longint'(it.player_y) + vert);
        p.camera_z = clamp_coord(longint'(it.player_z) - scale_q30(horiz, ct));
        p.camera_pitch = pitch;
        p.camera_yaw = wrap_turn(HALF - longint'(theta));
        return p;
    endfunction

    function void note_input(ocp_pkg::ocp_in_t it);
        case (it.mode)
            ocp_pkg::MODE_WHEEL: begin
                zoom_step = it.wheel_delta;
            end
            ocp_pkg::MODE_MOVE: begin
                turn_step = 21'(round_fifth(longint'(it.mouse_dx) * 96));
                tilt_step = 19'(round_fifth(longint'(it.mouse_dy) * 32));
            end
            ocp_pkg::MODE_FRAME: begin
                pose_q.push_back(frame_pose(it));
            end
            default: begin
            end
        endcase
    endfunction

    function void compare(string field, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check_pose(ocp_pkg::ocp_out_t got);
        ocp_pkg::ocp_out_t want;
        if (pose_q.size() == 0) begin
            $display("%0t: result transfer with no frame pending, got %h", $time, got);
            errors++;
            return;
        end
        want = pose_q.pop_front();
        compare("camera_x", want.camera_x, got.camera_x);
        compare("camera_y", want.camera_y, got.camera_y);
        compare("camera_z", want.camera_z, got.camera_z);
        compare("camera_pitch", want.camera_pitch, got.camera_pitch);
        compare("camera_yaw", want.camera_yaw, got.camera_yaw);
    endfunction
endclass

module tb_top;
    import ocp_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE_CYCLES = 2 * TRIG_ITERATIONS_DEF + 20;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    ocp_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    ocp_out_t m_data;
    int       send_profile;

    camera_scoreboard sb = new();

    orbit_camera_position_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("%0t: timeout with %0d poses outstanding", $time, sb.backlog());
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic int pick_gap(int profile);
        int r;
        if (profile == 0) begin
            return 0;
        end
        r = int'($urandom_range(99));
        if (r < 50) begin
            return 0;
        end
        if (r < 93) begin
            return int'($urandom_range(4, 1));
        end
        return int'($urandom_range(40, 10));
    endfunction

    initial begin : result_sink
        int stall_left;
        int profile;
        int dwell;
        stall_left = 0;
        profile = 1;
        dwell = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (dwell == 0) begin
                profile = int'($urandom_range(2));
                dwell = int'($urandom_range(400, 50));
            end
            dwell--;
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (aresetn && $urandom_range(99) < 20 * profile) begin
                m_ready <= 1'b0;
                stall_left = pick_gap(profile);
            end else begin
                m_ready <= aresetn;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            sb.check_pose(m_data);
        end
    end

    function automatic logic signed [23:0] rand_coord();
        int r;
        r = int'($urandom_range(9));
        if (r == 0) begin
            return 24'sh7FFFFF;
        end
        if (r == 1) begin
            return 24'sh800000;
        end
        if (r < 5) begin
            return 24'($urandom);
        end
        return 24'($urandom_range(131072)) - 24'd65536;
    endfunction

    function automatic ocp_in_t rand_item(logic [1:0] mode);
        ocp_in_t it;
        it.mode = mode;
        it.wheel_delta = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(16)) - 8'd8;
        it.mouse_dx = ($urandom_range(3) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(400)) - 16'd200;
        it.mouse_dy = ($urandom_range(3) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(400)) - 16'd200;
        it.left_button = 1'($urandom);
        it.right_button = 1'($urandom);
        it.player_x = rand_coord();
        it.player_y = rand_coord();
        it.player_z = rand_coord();
        it.player_heading = 15'($urandom);
        return it;
    endfunction

    function automatic ocp_in_t make_item(logic [1:0] mode, logic signed [7:0] wheel,
                                          logic signed [15:0] dx, logic signed [15:0] dy,
                                          logic left, logic right,
                                          logic signed [23:0] px, logic signed [23:0] py,
                                          logic signed [23:0] pz, logic [14:0] heading);
        ocp_in_t it;
        it.mode = mode;
        it.wheel_delta = wheel;
        it.mouse_dx = dx;
        it.mouse_dy = dy;
        it.left_button = left;
        it.right_button = right;
        it.player_x = px;
        it.player_y = py;
        it.player_z = pz;
        it.player_heading = heading;
        return it;
    endfunction

    task automatic send_item(input ocp_in_t it);
        int gap;
        gap = pick_gap(send_profile);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_input(it);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.backlog() > 0);
    endtask

    task automatic run_directed();
        send_item(make_item(MODE_FRAME, 8'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0,
                            24'sd0, 24'sd0, 24'sd0, 15'd0));
        send_item(make_item(MODE_WHEEL, 8'sd127, 16'sd0, 16'sd0, 1'b0, 1'b0,
                            24'sd0, 24'sd0, 24'sd0, 15'd0));
        send_item(make_item(MODE_FRAME, 8'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0,
                            24'sd0, 24'sd0, 24'sd0, 15'd5760));
        send_item(make_item(MODE_WHEEL, 8'sh80, 16'sd0, 16'sd0, 1'b0, 1'b0,
                            24'sd0, 24'sd0, 24'sd0, 15'd0));
        send_item(make_item(MODE_FRAME, 8'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0,
                            24'sd1000, -24'sd1000, 24'sd0, 15'd11520));
        send_item(make_item(MODE_MOVE, 8'sd0, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0,
                            24'sd0, 24'sd0, 24'sd0, 15'd0));
        send_item(make_item(MODE_FRAME, 8'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1,
                            24'sd0, 24'sd0, 24'sd0, 15'd17280));
        send_item(make_item(MODE_FRAME, 8'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0,
                            24'sd0, 24'sd0, 24'sd0, 15'd23039));
        send_item(make_item(MODE_MOVE, 8'sd0, 16'sh8000, 16'sh7FFF, 1'b0, 1'b0,
                            24'sd0, 24'sd0, 24'sd0, 15'd0));
        send_item(make_item(MODE_FRAME, 8'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1,
                            24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 15'd23040));
        send_item(make_item(MODE_FRAME, 8'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0,
                            24'sh800000, 24'sh800000, 24'sh800000, 15'h7FFF));
        send_item(make_item(MODE_UNUSED, 8'shFF, 16'shFFFF, 16'shFFFF, 1'b1, 1'b1,
                            24'shFFFFFF, 24'shFFFFFF, 24'shFFFFFF, 15'h7FFF));
        send_item(make_item(MODE_FRAME, 8'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1,
                            24'sd0, 24'sd0, 24'sd0, 15'd1));
        send_item(make_item(MODE_WHEEL, 8'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0,
                            24'sd0, 24'sd0, 24'sd0, 15'd0));
        send_item(make_item(MODE_MOVE, 8'sd0, 16'sd1, -16'sd1, 1'b0, 1'b0,
                            24'sd0, 24'sd0, 24'sd0, 15'd0));
        send_item(make_item(MODE_FRAME, 8'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1,
                            24'sh7FFFFF, 24'sd0, 24'sh800000, 15'd12000));
        send_item(make_item(MODE_MOVE, 8'sd0, 16'sd5, -16'sd5, 1'b0, 1'b0,
                            24'sd0, 24'sd0, 24'sd0, 15'd0));
        send_item(make_item(MODE_FRAME, 8'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1,
                            24'sd512, 24'sd512, 24'sd512, 15'd100));
        send_item(make_item(MODE_FRAME, 8'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0,
                            -24'sd512, -24'sd512, -24'sd512, 15'd22000));
    endtask

    task automatic run_random(input int target);
        int         done;
        bit         paused;
        logic [1:0] mode;
        done = 0;
        paused = 1'b0;
        while (done < target) begin
            if ($urandom_range(49) == 0) begin
                send_profile = int'($urandom_range(2));
            end
            if (!paused && done >= target / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
            if ($urandom_range(9) < 8) begin
                if ($urandom_range(1) == 1) begin
                    send_item(rand_item(MODE_WHEEL));
                    done++;
                end
                if ($urandom_range(4) < 3) begin
                    send_item(rand_item(MODE_MOVE));
                    done++;
                end
                send_item(rand_item(MODE_FRAME));
                done++;
            end else begin
                mode = 2'($urandom);
                send_item(rand_item(mode));
                if (mode != MODE_UNUSED) begin
                    done++;
                end
            end
        end
    endtask

    // Full outward zoom on every frame drives the distance into its upper limit.
    task automatic run_zoom_sweep(input int frames);
        ocp_in_t it;
        repeat (frames) begin
            if ($urandom_range(49) == 0) begin
                send_profile = int'($urandom_range(2));
            end
            it = rand_item(MODE_WHEEL);
            it.wheel_delta = 8'sh80;
            send_item(it);
            send_item(rand_item(MODE_FRAME));
        end
    endtask

    initial begin : stimulus
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        send_profile = 1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        wait_for_results();
        run_random(300);
        run_zoom_sweep(520);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.backlog() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
